/* hw/rtl/job_slot_table_core_assert.svh */
// ----------------------------------------------------------------------------
// Job slot table assertion macros
// Shared concurrent assertion forms for the job slot table RTL.
// ----------------------------------------------------------------------------
`ifndef JOB_SLOT_TABLE_CORE_ASSERT_SVH
`define JOB_SLOT_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define JST_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("job slot table check failed");

// next-cycle implication
`define JST_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("job slot table check failed");

`endif

/* hw/rtl/jst_pkg.sv */
// ----------------------------------------------------------------------------
// Job slot table package
// Sizes, codes and request/result types shared by the job slot table.
// ----------------------------------------------------------------------------
package jst_pkg;

  localparam int ENTRIES = 32;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int KEY_W   = 22;
  localparam int PAY_W   = 16;
  localparam int JN_W    = 8;
  localparam int SLOT_W  = 6;
  localparam int IN_DATA_W  = ((KEY_W + PAY_W + JN_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((SLOT_W + KEY_W + PAY_W + SLOT_W + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_DEL_KEY = 2'd1,
    ACT_GET_NUM = 2'd2,
    ACT_GET_KEY = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_MISS = 2'd1,
    STS_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_SCAN,
    S_NUM,
    S_DONE
  } state_t;

  typedef struct packed {
    action_t           action;
    logic [KEY_W-1:0]  key;
    logic [PAY_W-1:0]  payload;
    logic [JN_W-1:0]   job_number;
  } jst_cmd_t;

  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot_number;
    logic [KEY_W-1:0]  found_key;
    logic [PAY_W-1:0]  found_payload;
    logic [SLOT_W-1:0] used_count;
  } jst_res_t;

endpackage

/* hw/rtl/jst_engine.sv */
// ----------------------------------------------------------------------------
// Job slot table engine
// Slot storage plus a sequencer that walks the slots one per cycle.
// ----------------------------------------------------------------------------
`include "job_slot_table_core_assert.svh"

module jst_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  jst_pkg::jst_cmd_t cmd,
  output logic             res_valid,
  input  logic             res_ready,
  output jst_pkg::jst_res_t res
);
  import jst_pkg::*;

  state_t              state;
  state_t              state_next;
  jst_cmd_t            cmd_r;
  logic [ENTRIES-1:0]  slot_valid;
  logic [CNT_W-1:0]    occupied;
  logic [CNT_W-1:0]    cnt;
  logic [IDX_W-1:0]    scan_idx;
  logic                p_vld;
  logic [IDX_W-1:0]    p_idx;
  logic                p_valid;

  logic [KEY_W-1:0]    key_mem [ENTRIES];
  logic [PAY_W-1:0]    pay_mem [ENTRIES];
  logic [KEY_W-1:0]    rd_key;
  logic [PAY_W-1:0]    rd_pay;

  status_t             res_status;
  logic [SLOT_W-1:0]   res_slot;
  logic [KEY_W-1:0]    res_key;
  logic [PAY_W-1:0]    res_pay;

  logic                start;
  logic                issue;
  logic                hit;
  logic                miss;
  logic                add_free;
  logic                add_full;
  logic                num_ok;
  logic [IDX_W-1:0]    num_idx;
  logic                mem_re;
  logic [IDX_W-1:0]    rd_addr;
  logic                mem_we;

  assign scan_idx = cnt[IDX_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.action)
            ACT_ADD:     state_next = S_ADD;
            ACT_GET_NUM: state_next = S_NUM;
            default:     state_next = S_SCAN;
          endcase
        end
      end
      S_ADD:  if (add_free || add_full) state_next = S_DONE;
      S_SCAN: if (hit || miss) state_next = S_DONE;
      S_NUM:  state_next = S_DONE;
      S_DONE: if (res_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_ready = (state == S_IDLE);
    res_valid = (state == S_DONE);
    start     = cmd_valid && cmd_ready;
    num_ok    = (cmd.job_number != '0) && (cmd.job_number <= JN_W'(ENTRIES));
    num_idx   = IDX_W'(cmd.job_number - JN_W'(1));
    issue     = (state == S_SCAN) && (cnt < CNT_W'(ENTRIES));
    hit       = (state == S_SCAN) && p_vld && p_valid && (rd_key == cmd_r.key);
    miss      = (state == S_SCAN) && !issue && !p_vld;
    add_free  = (state == S_ADD) && !slot_valid[scan_idx];
    add_full  = (state == S_ADD) && slot_valid[scan_idx] &&
                (cnt == CNT_W'(ENTRIES - 1));
    mem_we    = add_free;
    mem_re    = issue || (start && (cmd.action == ACT_GET_NUM));
    rd_addr   = issue ? scan_idx : num_idx;
  end

  // slot storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[scan_idx] <= cmd_r.key;
      pay_mem[scan_idx] <= cmd_r.payload;
    end
    if (mem_re) begin
      rd_key <= key_mem[rd_addr];
      rd_pay <= pay_mem[rd_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      occupied   <= '0;
      p_vld      <= 1'b0;
    end else begin
      state <= state_next;
      if (start) begin
        p_vld <= 1'b0;
      end else if (state == S_SCAN) begin
        p_vld <= issue;
      end
      if (add_free) begin
        slot_valid[scan_idx] <= 1'b1;
        occupied             <= occupied + CNT_W'(1);
      end
      if (hit && (cmd_r.action == ACT_DEL_KEY)) begin
        slot_valid[p_idx] <= 1'b0;
        occupied          <= occupied - CNT_W'(1);
      end
    end
  end

  // working registers and result
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r   <= cmd;
      cnt     <= '0;
      p_valid <= num_ok && slot_valid[num_idx];
    end else if (issue) begin
      cnt     <= cnt + CNT_W'(1);
      p_idx   <= scan_idx;
      p_valid <= slot_valid[scan_idx];
    end else if ((state == S_ADD) && !add_free && !add_full) begin
      cnt <= cnt + CNT_W'(1);
    end

    if (add_free) begin
      res_status <= STS_OK;
      res_slot   <= SLOT_W'(cnt + CNT_W'(1));
      res_key    <= cmd_r.key;
      res_pay    <= cmd_r.payload;
    end else if (add_full || miss || ((state == S_NUM) && !p_valid)) begin
      res_status <= add_full ? STS_FULL : STS_MISS;
      res_slot   <= '0;
      res_key    <= '0;
      res_pay    <= '0;
    end else if (hit) begin
      res_status <= STS_OK;
      res_slot   <= SLOT_W'(CNT_W'(p_idx) + CNT_W'(1));
      res_key    <= rd_key;
      res_pay    <= rd_pay;
    end else if (state == S_NUM) begin
      res_status <= STS_OK;
      res_slot   <= SLOT_W'(cmd_r.job_number);
      res_key    <= rd_key;
      res_pay    <= rd_pay;
    end
  end

  // used count is read live: it settles on the edge that enters S_DONE
  assign res = '{status:        res_status,
                 slot_number:   res_slot,
                 found_key:     res_key,
                 found_payload: res_pay,
                 used_count:    SLOT_W'(occupied)};

  `JST_ASSERT_IMP(a_count_matches, clk, rst, 1'b1, $countones(slot_valid) == occupied)
  `JST_ASSERT_IMP(a_full_means_full, clk, rst, res_valid && (res.status == STS_FULL), occupied == CNT_W'(ENTRIES))
  `JST_ASSERT_IMP(a_ok_has_slot, clk, rst, res_valid && (res.status == STS_OK), res.slot_number != '0)
  `JST_ASSERT_NXT(a_result_holds, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

endmodule

/* hw/rtl/job_slot_table_core.sv */
// ----------------------------------------------------------------------------
// Job slot table core
// Fixed table of job slots with add, delete by key and two kinds of lookup.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_* stream (action on s_tuser, key, payload and job
//   number on s_tdata); exactly one result per request leaves on the m_*
//   stream (status on m_tuser, slot number, key, payload and used count on
//   m_tdata).
//   Add walks the valid marks one slot per cycle up to the first free one.
//   Delete and lookup by key stream the slots through the key compare one
//   per cycle, stopping at a hit or after the last slot. Lookup by number
//   is one memory read. The slot walk is the limiter: one request is in
//   work at a time and s_tready is low meanwhile.
//   The result lands in an output register, so a new request is taken while
//   the previous result waits for m_tready; if the receiver stalls longer,
//   the engine holds its finished result and does not accept more.
//   Reset clears every valid mark and the used count at once; the key and
//   payload storage is not cleared and the block is ready right away.
// ----------------------------------------------------------------------------
`include "job_slot_table_core_assert.svh"

module job_slot_table_core (
  input  logic                           clk,
  input  logic                           rst,
  // request channel
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [jst_pkg::IN_DATA_W-1:0]  s_tdata,  // key, payload, job_number, zero pad
  input  logic [1:0]                     s_tuser,  // action
  // result channel
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [jst_pkg::OUT_DATA_W-1:0] m_tdata,  // slot_number, found_key,
                                                   // found_payload, used_count, zero pad
  output logic [1:0]                     m_tuser   // status
);
  import jst_pkg::*;

  localparam int IN_USED  = KEY_W + PAY_W + JN_W;
  localparam int OUT_USED = SLOT_W + KEY_W + PAY_W + SLOT_W;

  jst_cmd_t cmd;
  jst_res_t eng_res;
  jst_res_t out_res;
  logic     eng_res_valid;
  logic     eng_res_ready;

  // unpack the request, lowest field first
  assign cmd.action     = action_t'(s_tuser);
  assign cmd.key        = s_tdata[KEY_W-1:0];
  assign cmd.payload    = s_tdata[KEY_W +: PAY_W];
  assign cmd.job_number = s_tdata[KEY_W+PAY_W +: JN_W];

  jst_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (s_tvalid),
    .cmd_ready (s_tready),
    .cmd       (cmd),
    .res_valid (eng_res_valid),
    .res_ready (eng_res_ready),
    .res       (eng_res)
  );

  // output register: free when empty or being drained this cycle
  assign eng_res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (eng_res_ready) begin
      m_tvalid <= eng_res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_res_ready && eng_res_valid) begin
      out_res <= eng_res;
    end
  end

  assign m_tuser = out_res.status;
  assign m_tdata = {{(OUT_DATA_W - OUT_USED){1'b0}},
                    out_res.used_count,
                    out_res.found_payload,
                    out_res.found_key,
                    out_res.slot_number};

  `JST_ASSERT_NXT(a_one_in_flight, clk, rst, s_tvalid && s_tready, !s_tready)
  `JST_ASSERT_IMP(a_pad_unused, clk, rst, s_tvalid && s_tready, IN_USED <= IN_DATA_W)
  `JST_ASSERT_NXT(a_result_loads, clk, rst, eng_res_valid && eng_res_ready, m_tvalid)

endmodule
